// ===== hdl/smie_pkg.sv =====
// Shared types and constants for the stack machine instruction executor.
// No dependencies; imported by smie_alu, the top level and the testbench.
package smie_pkg;

  localparam int WORD_W              = 32;
  localparam int DEFAULT_STACK_DEPTH = 256;
  localparam int DEPTH_OUT_W         = 9;
  localparam int STATUS_W            = 3;
  localparam int KIND_LSB            = 30;
  localparam int DATA_W              = 30;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_HALTED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NEGROOT   = 3'd5;

  // Primitive codes
  localparam logic [DATA_W-1:0] PRIM_HALT = 30'd0;
  localparam logic [DATA_W-1:0] PRIM_ADD  = 30'd1;
  localparam logic [DATA_W-1:0] PRIM_SUB  = 30'd2;
  localparam logic [DATA_W-1:0] PRIM_MUL  = 30'd3;
  localparam logic [DATA_W-1:0] PRIM_DIV  = 30'd4;
  localparam logic [DATA_W-1:0] PRIM_POW  = 30'd5;
  localparam logic [DATA_W-1:0] PRIM_SQRT = 30'd6;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_POW,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  // Map a binary primitive code to its unit operation
  function automatic alu_op_t prim_to_op(input logic [DATA_W-1:0] code);
    alu_op_t op;
    unique case (code)
      PRIM_ADD: op = ALU_ADD;
      PRIM_SUB: op = ALU_SUB;
      PRIM_MUL: op = ALU_MUL;
      PRIM_DIV: op = ALU_DIV;
      PRIM_POW: op = ALU_POW;
      default:  op = ALU_SQRT;
    endcase
    return op;
  endfunction

endpackage

// ===== hdl/smie_alu.sv =====
// Iterative arithmetic unit: add, subtract, multiply, divide, power, root.
// One shared 32x32 multiplier, one subtractor path per step. Uses smie_pkg.
module smie_alu (
  input  logic                             clk,
  input  logic                             rst,
  input  smie_pkg::alu_ctl_t               ctl,
  input  logic [smie_pkg::WORD_W-1:0]      a,
  input  logic [smie_pkg::WORD_W-1:0]      b,
  output logic [smie_pkg::WORD_W-1:0]      result,
  output logic                             done
);
  import smie_pkg::*;

  localparam logic [4:0] POW_LAST  = 5'd30;
  localparam logic [4:0] DIV_LAST  = 5'd31;
  localparam logic [4:0] SQRT_LAST = 5'd15;
  localparam logic [WORD_W-1:0] ALL_ONES  = '1;
  localparam logic [WORD_W-1:0] ONE       = 32'd1;
  localparam logic [WORD_W-1:0] ROOT_BIT0 = 32'h4000_0000;

  alu_op_t           op;
  logic              busy;
  logic              phase;
  logic              neg;
  logic [4:0]        cnt;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] sq;
  logic [WORD_W-1:0] opnd;
  logic [WORD_W-1:0] rem;

  logic [WORD_W-1:0] mul_l;
  logic [WORD_W-1:0] prod;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W+1:0] div_diff;
  logic              qbit;
  logic [WORD_W-1:0] q_next;
  logic [WORD_W:0]   root_try;

  // Shared multiplier, low word only
  assign mul_l = phase ? sq : acc;
  assign prod  = mul_l * sq;

  // Restoring division step
  assign rem_sh   = {rem, sq[WORD_W-1]};
  assign div_diff = {1'b0, rem_sh} - {2'b00, opnd};
  assign qbit     = !div_diff[WORD_W+1];
  assign q_next   = {acc[WORD_W-2:0], qbit};

  // Root trial value
  assign root_try = {1'b0, acc} + {1'b0, opnd};

  assign result = acc;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (ctl.start) begin
      op    <= ctl.op;
      cnt   <= '0;
      phase <= 1'b0;
      unique case (ctl.op)
        ALU_ADD: begin
          acc  <= a + b;
          done <= 1'b1;
        end
        ALU_SUB: begin
          acc  <= a - b;
          done <= 1'b1;
        end
        ALU_MUL: begin
          acc  <= a;
          sq   <= b;
          busy <= 1'b1;
        end
        ALU_DIV: begin
          sq   <= a[WORD_W-1] ? -a : a;
          opnd <= b[WORD_W-1] ? -b : b;
          rem  <= '0;
          acc  <= '0;
          neg  <= a[WORD_W-1] ^ b[WORD_W-1];
          busy <= 1'b1;
        end
        ALU_POW: begin
          if (b[WORD_W-1]) begin
            // negative exponent: only unit magnitudes survive
            if (a == ONE) acc <= ONE;
            else if (a == ALL_ONES) acc <= b[0] ? ALL_ONES : ONE;
            else acc <= '0;
            done <= 1'b1;
          end else begin
            acc  <= ONE;
            sq   <= a;
            opnd <= b;
            busy <= 1'b1;
          end
        end
        default: begin
          sq   <= a;
          acc  <= '0;
          opnd <= ROOT_BIT0;
          busy <= 1'b1;
        end
      endcase
    end else if (busy) begin
      unique case (op)
        ALU_MUL: begin
          acc  <= prod;
          busy <= 1'b0;
          done <= 1'b1;
        end
        ALU_POW: begin
          if (!phase) begin
            if (opnd[0]) acc <= prod;
            phase <= 1'b1;
          end else begin
            sq    <= prod;
            opnd  <= opnd >> 1;
            phase <= 1'b0;
            cnt   <= cnt + 5'd1;
            if (cnt == POW_LAST) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        end
        ALU_DIV: begin
          rem <= qbit ? div_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
          sq  <= sq << 1;
          cnt <= cnt + 5'd1;
          if (cnt == DIV_LAST) begin
            acc  <= neg ? -q_next : q_next;
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            acc <= q_next;
          end
        end
        default: begin
          if ({1'b0, sq} >= root_try) begin
            sq  <= sq - root_try[WORD_W-1:0];
            acc <= (acc >> 1) + opnd;
          end else begin
            acc <= acc >> 1;
          end
          opnd <= opnd >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == SQRT_LAST) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      endcase
    end
  end

endmodule

// ===== hdl/stack_machine_instruction_executor_top.sv =====
// Stack machine instruction executor. Push, halt, unknown codes and error cases are answered
// straight from the idle state; binary primitives pass through operand load, unit run and commit
// states, square root skipping the load; power runs 31 square-and-multiply steps.
// One item in flight; the next is taken once the result is registered and the output is free.
// Reset (rst, synchronous): stack empty, not halted, no result pending. Stack memory
// contents are not cleared; only written entries are ever read.
module stack_machine_instruction_executor_top #(
  parameter int STACK_DEPTH = smie_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [smie_pkg::WORD_W-1:0]         instruction_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [smie_pkg::WORD_W-1:0]  top_value,
  output logic [smie_pkg::DEPTH_OUT_W-1:0]    stack_depth,
  output logic [smie_pkg::STATUS_W-1:0]       status,
  output logic                                halted
);
  import smie_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] C1   = CW'(1);
  localparam logic [CW-1:0] C2   = CW'(2);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd;

  logic [1:0]        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic              halt, halt_next;
  logic [WORD_W-1:0] top, top_next;
  alu_op_t           pend_op, pend_op_next;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [CW-1:0]     cnt_m1, cnt_m2;

  logic              out_free, accept, out_load;
  logic [STATUS_W-1:0] st;

  alu_ctl_t          alu_ctl;
  logic [WORD_W-1:0] alu_a, alu_res;
  logic              alu_done;

  logic [1:0]        kind;
  logic [DATA_W-1:0] data;

  assign kind   = instruction_word[WORD_W-1:KIND_LSB];
  assign data   = instruction_word[DATA_W-1:0];
  assign cnt_m1 = count - C1;
  assign cnt_m2 = count - C2;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign alu_a = (state == S_IDLE) ? top : rd;

  smie_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (alu_ctl),
    .a      (alu_a),
    .b      (top),
    .result (alu_res),
    .done   (alu_done)
  );

  // Decode, sequence and commit
  always_comb begin
    state_next   = state;
    count_next   = count;
    halt_next    = halt;
    top_next     = top;
    pend_op_next = pend_op;
    we           = 1'b0;
    waddr        = count[AW-1:0];
    wdata        = top;
    out_load     = 1'b0;
    st           = ST_OK;
    alu_ctl      = '{start: 1'b0, op: ALU_SQRT};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (halt) begin
            out_load = 1'b1;
            st       = ST_HALTED;
          end else if (!kind[0]) begin
            out_load = 1'b1;
            if (count >= FULL) begin
              st = ST_OVERFLOW;
            end else begin
              we         = 1'b1;
              waddr      = count[AW-1:0];
              wdata      = WORD_W'(data);
              top_next   = WORD_W'(data);
              count_next = count + C1;
            end
          end else if (data == PRIM_HALT) begin
            out_load  = 1'b1;
            halt_next = 1'b1;
          end else if (data == PRIM_SQRT) begin
            if (count < C1) begin
              out_load = 1'b1;
              st       = ST_UNDERFLOW;
            end else if (top[WORD_W-1]) begin
              out_load = 1'b1;
              st       = ST_NEGROOT;
            end else begin
              alu_ctl      = '{start: 1'b1, op: ALU_SQRT};
              pend_op_next = ALU_SQRT;
              state_next   = S_RUN;
            end
          end else if (data > PRIM_SQRT) begin
            out_load = 1'b1;
          end else if (count < C2) begin
            out_load = 1'b1;
            st       = ST_UNDERFLOW;
          end else if (data == PRIM_DIV && top == '0) begin
            out_load = 1'b1;
            st       = ST_DIVZERO;
          end else begin
            pend_op_next = prim_to_op(data);
            state_next   = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        alu_ctl    = '{start: 1'b1, op: pend_op};
        state_next = S_RUN;
      end
      S_RUN: begin
        if (alu_done) state_next = S_FIN;
      end
      default: begin
        if (out_free) begin
          out_load   = 1'b1;
          we         = 1'b1;
          wdata      = alu_res;
          top_next   = alu_res;
          state_next = S_IDLE;
          if (pend_op == ALU_SQRT) begin
            waddr = cnt_m1[AW-1:0];
          end else begin
            waddr      = cnt_m2[AW-1:0];
            count_next = cnt_m1;
          end
        end
      end
    endcase
  end

  // Stack memory: one write port, registered read of the entry under the top
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[cnt_m2[AW-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      halt      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      halt  <= halt_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top     <= top_next;
    pend_op <= pend_op_next;
    if (out_load) begin
      top_value   <= (count_next == '0) ? '0 : top_next;
      stack_depth <= DEPTH_OUT_W'(count_next);
      status      <= st;
      halted      <= halt_next;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("stack count beyond depth");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halt |=> halt)
    else $error("halt flag cleared");
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> state == S_RUN)
    else $error("unit finished outside run state");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |=> (state == S_RUN))
    else $error("operand load not followed by run");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for stack_machine_instruction_executor_top.
// Depends on smie_pkg; predicts every result in-line and checks it in order.
`timescale 1ns / 1ps

module tb_top;
  import smie_pkg::*;

  localparam int          DEPTH      = DEFAULT_STACK_DEPTH;
  localparam int          RAND_ITEMS = 650;
  localparam int          IDLE_LIMIT = 3000;
  localparam logic [1:0]  KIND_PUSH  = 2'd0;
  localparam logic [1:0]  KIND_PRIM  = 2'd1;
  localparam logic [1:0]  KIND_PUSH2 = 2'd2;
  localparam logic [1:0]  KIND_PRIM2 = 2'd3;

  typedef struct {
    logic [WORD_W-1:0]      top;
    logic [DEPTH_OUT_W-1:0] depth;
    logic [STATUS_W-1:0]    st;
    logic                   hlt;
  } step_result_t;

  logic                           clk, rst;
  logic                           in_valid, in_stall;
  logic [WORD_W-1:0]              instruction_word;
  logic                           out_valid, out_stall;
  logic signed [WORD_W-1:0]       top_value;
  logic [DEPTH_OUT_W-1:0]         stack_depth;
  logic [STATUS_W-1:0]            status;
  logic                           halted;

  logic [WORD_W-1:0] pending_words[$];
  step_result_t      expected_results[$];

  // Predicted machine state
  logic [WORD_W-1:0] model_stack[DEPTH];
  int                model_count;
  logic              model_halt;

  int  gen_depth;
  bit  failed;
  int  idle_cycles;

  stack_machine_instruction_executor_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .instruction_word(instruction_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .top_value(top_value), .stack_depth(stack_depth), .status(status), .halted(halted)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Floor square root, built bit by bit from the top
  function automatic logic [31:0] isqrt(input logic [31:0] v);
    logic [31:0] r, t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (64'(t) * 64'(t) <= 64'(v)) r = t;
    end
    return r;
  endfunction

  // Wrapping integer power; negative exponents only survive for unit bases
  function automatic logic [31:0] ipow(input logic [31:0] base, input logic [31:0] ex);
    logic [31:0] acc, sq;
    if (ex[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == 32'hffffffff) return ex[0] ? 32'hffffffff : 32'd1;
      return 32'd0;
    end
    acc = 1;
    sq  = base;
    for (int i = 0; i < 31; i++) begin
      if (ex[i]) acc = acc * sq;
      sq = sq * sq;
    end
    return acc;
  endfunction

  function automatic logic [31:0] idiv(input logic [31:0] a, input logic [31:0] b);
    longint q;
    q = longint'($signed(a)) / longint'($signed(b));
    return q[31:0];
  endfunction

  // Execute one word on the predicted machine and queue the result
  task automatic execute_word(input logic [WORD_W-1:0] w);
    logic [1:0]        kind;
    logic [DATA_W-1:0] code;
    logic [31:0]       a, b, r;
    logic [2:0]        st;
    step_result_t      res;
    kind = w[31:30];
    code = w[DATA_W-1:0];
    st   = ST_OK;
    if (model_halt) begin
      st = ST_HALTED;
    end else if (kind == KIND_PUSH || kind == KIND_PUSH2) begin
      if (model_count >= DEPTH) st = ST_OVERFLOW;
      else begin
        model_stack[model_count] = {2'b00, code};
        model_count++;
      end
    end else if (code == PRIM_HALT) begin
      model_halt = 1'b1;
    end else if (code == PRIM_SQRT) begin
      if (model_count < 1) st = ST_UNDERFLOW;
      else if (model_stack[model_count-1][31]) st = ST_NEGROOT;
      else model_stack[model_count-1] = isqrt(model_stack[model_count-1]);
    end else if (code <= PRIM_POW) begin
      if (model_count < 2) st = ST_UNDERFLOW;
      else begin
        a = model_stack[model_count-2];
        b = model_stack[model_count-1];
        r = 0;
        case (code)
          PRIM_ADD: r = a + b;
          PRIM_SUB: r = a - b;
          PRIM_MUL: r = a * b;
          PRIM_DIV: if (b == 0) st = ST_DIVZERO; else r = idiv(a, b);
          default:  r = ipow(a, b);
        endcase
        if (st == ST_OK) begin
          model_stack[model_count-2] = r;
          model_count--;
        end
      end
    end
    res.top   = (model_count > 0) ? model_stack[model_count-1] : 32'd0;
    res.depth = model_count[DEPTH_OUT_W-1:0];
    res.st    = st;
    res.hlt   = model_halt;
    expected_results.push_back(res);
  endtask

  // Stimulus helpers; gen_depth is only a rough guide for shaping sequences
  task automatic push_val(input logic [DATA_W-1:0] v);
    pending_words.push_back({($urandom_range(0, 1) ? KIND_PUSH2 : KIND_PUSH), v});
    if (gen_depth < DEPTH) gen_depth++;
  endtask

  task automatic prim(input logic [DATA_W-1:0] code);
    pending_words.push_back({($urandom_range(0, 1) ? KIND_PRIM2 : KIND_PRIM), code});
    if (code >= PRIM_ADD && code <= PRIM_POW && gen_depth >= 2) gen_depth--;
  endtask

  task automatic push_neg(input logic [DATA_W-1:0] v);
    push_val(DATA_W'(0));
    push_val(v);
    prim(PRIM_SUB);
  endtask

  function automatic logic [DATA_W-1:0] rand_data();
    case ($urandom_range(0, 3))
      0:       return DATA_W'($urandom_range(0, 3));
      1:       return DATA_W'($urandom_range(0, 40));
      2:       return DATA_W'($urandom_range(0, 65535));
      default: return DATA_W'($urandom());
    endcase
  endfunction

  // Driver: hold the word until transfer, then advance after a random gap
  int  in_gap;
  bit  in_steady;
  always @(posedge clk) begin
    logic v;
    if (rst) begin
      in_valid <= 1'b0;
      instruction_word <= '0;
      in_gap = 0;
      in_steady = 0;
    end else begin
      v = in_valid;
      if (in_valid && !in_stall) begin
        execute_word(instruction_word);
        v = 1'b0;
      end
      if (!v) begin
        if (in_gap > 0) in_gap--;
        else if (pending_words.size() > 0) begin
          instruction_word <= pending_words.pop_front();
          v = 1'b1;
          if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
          in_gap = in_steady ? 0 : $urandom_range(0, 13);
        end
      end
      in_valid <= v;
    end
  end

  // Monitor: check each transfer against the oldest expectation
  int  out_hold;
  bit  out_steady;
  always @(posedge clk) begin
    step_result_t e;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold = 0;
      out_steady = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result top=%h depth=%0d status=%0d halted=%0b",
                   $time, top_value, stack_depth, status, halted);
          failed = 1;
        end else begin
          e = expected_results.pop_front();
          if (top_value !== e.top) begin
            $display("%0t: top_value expected %h actual %h", $time, e.top, top_value);
            failed = 1;
          end
          if (stack_depth !== e.depth) begin
            $display("%0t: stack_depth expected %0d actual %0d", $time, e.depth, stack_depth);
            failed = 1;
          end
          if (status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status);
            failed = 1;
          end
          if (halted !== e.hlt) begin
            $display("%0t: halted expected %0b actual %0b", $time, e.hlt, halted);
            failed = 1;
          end
        end
        if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
        out_hold = out_steady ? 0 : $urandom_range(0, 13);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold > 0);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("stack_machine_instruction_executor_top regression: fail");
      $finish;
    end
  end

  initial begin
    int r;
    bit filled;
    rst = 1'b1;
    model_count = 0;
    model_halt = 0;
    gen_depth = 0;
    failed = 0;
    idle_cycles = 0;

    // Directed: underflow, extremes, each arithmetic primitive and its corner cases
    prim(PRIM_ADD);
    prim(PRIM_SQRT);
    push_val(DATA_W'(32'h3fffffff));
    prim(PRIM_ADD);
    push_val(DATA_W'(0));
    prim(PRIM_DIV);
    push_val(DATA_W'(7));
    prim(PRIM_DIV);
    push_val(DATA_W'(3));
    prim(PRIM_MUL);
    prim(PRIM_SQRT);
    push_neg(DATA_W'(5));
    prim(PRIM_SQRT);
    prim(PRIM_POW);
    push_val(DATA_W'(0));
    push_val(DATA_W'(0));
    prim(PRIM_POW);
    push_val(DATA_W'(32'h3fffffff));
    pending_words.push_back({KIND_PRIM2, DATA_W'(32'h3fffffff)});
    prim(PRIM_SUB);
    // Most negative over minus one
    push_val(DATA_W'(32'h10000));
    push_val(DATA_W'(32'h8000));
    prim(PRIM_MUL);
    push_neg(DATA_W'(1));
    prim(PRIM_DIV);

    // Random: mostly well-formed operand/operator sequences
    filled = 0;
    while (pending_words.size() < RAND_ITEMS) begin
      if (!filled && pending_words.size() > RAND_ITEMS / 2) begin
        // fill the stack past its top once; later operators work it back down
        filled = 1;
        while (gen_depth < DEPTH) push_val(rand_data());
        repeat (3) push_val(rand_data());
        continue;
      end
      r = $urandom_range(0, 99);
      if (gen_depth < 2 || (r < 40 && gen_depth < 40)) push_val(rand_data());
      else if (r < 80) prim(DATA_W'($urandom_range(1, 5)));
      else if (r < 86) prim(PRIM_SQRT);
      else if (r < 90) prim(DATA_W'($urandom_range(7, 32'h3fffffff)));
      else if (r < 94) begin
        // unit bases with negated exponents for power
        if ($urandom_range(0, 1)) push_neg(DATA_W'(1)); else push_val(DATA_W'(1));
        push_neg(rand_data());
        prim(PRIM_POW);
      end else if (r < 97) begin
        push_val(rand_data());
        push_val(DATA_W'(0));
        prim(PRIM_DIV);
      end else begin
        push_neg(rand_data());
        prim(PRIM_SQRT);
      end
    end

    // Halt, then words that must be ignored
    prim(PRIM_HALT);
    push_val(DATA_W'($urandom()));
    prim(PRIM_ADD);
    pending_words.push_back({KIND_PRIM2, DATA_W'(32'h3fffffff)});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (80) @(posedge clk);
    if (!failed && expected_results.size() == 0)
      $display("stack_machine_instruction_executor_top regression: pass");
    else
      $display("stack_machine_instruction_executor_top regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/smie_pkg.sv
hdl/smie_alu.sv
hdl/stack_machine_instruction_executor_top.sv
tb/sv/tb_top.sv
